>>> src/ddim_pkg.sv
// Shared constants, register codes and coefficient type for the DDIM step unit.
`timescale 1ns / 1ps
package ddim_pkg;

    // Default sample width
    localparam int DEF_DATA_WIDTH = 24;

    // Coefficient format: unsigned Q.24
    localparam int                CF_BITS = 24;
    localparam int                CO_W    = 25;
    localparam logic [CO_W-1:0]   CF_ONE  = 25'h100_0000;
    localparam logic [CO_W-1:0]   SQ_MIN  = 25'd4096;

    // Intermediate x0 / eps limit, +-(2^36 - 1)
    localparam int                MID_W   = 38;
    localparam logic [MID_W-1:0]  MID_LIM = 38'h0F_FFFF_FFFF;

    // Register widths
    localparam int A_W        = 24;
    localparam int P_W        = 25;
    localparam int E_W        = 17;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 25;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_NOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_BEFORE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_LEVEL    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_MODE    = 4'd3;

    // Register reset values
    localparam logic [A_W-1:0]    ALPHA_NOW_RST    = 24'h80_0000;
    localparam logic [P_W-1:0]    ALPHA_BEFORE_RST = 25'h100_0000;
    localparam logic [E_W-1:0]    ETA_LEVEL_RST    = 17'd0;

    // Prediction modes
    localparam logic [MODE_W-1:0] MODE_EPS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VPRED  = 2'd2;

    // Per-step coefficients
    typedef struct packed {
        logic [CO_W-1:0] sa;
        logic [CO_W-1:0] sb;
        logic [CO_W-1:0] sap;
        logic [CO_W-1:0] dir;
        logic [CO_W-1:0] sd;
    } t_coef;

endpackage

>>> src/ddim_coef.sv
// Sequential coefficient engine: square roots, quotients and products of the step.
`timescale 1ns / 1ps
module ddim_coef (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ddim_pkg::A_W-1:0]    i_alpha_now,
    input  logic [ddim_pkg::P_W-1:0]    i_alpha_before,
    input  logic [ddim_pkg::E_W-1:0]    i_eta_level,
    output ddim_pkg::t_coef             o_coef,
    output logic                        o_busy
);
    import ddim_pkg::*;

    typedef enum logic [3:0] {
        S_SA, S_SB, S_SAP, S_R1, S_R2, S_VAR, S_SV, S_SD, S_SD2, S_DIR, S_DONE
    } t_state;

    t_state             r_state;
    logic               r_run;
    logic [5:0]         r_cnt;
    logic [63:0]        r_sq_val;
    logic [34:0]        r_sq_rem;
    logic [31:0]        r_sq_root;
    logic [47:0]        r_dv_num;
    logic [25:0]        r_dv_rem;
    logic [24:0]        r_dv_q;
    logic [CO_W-1:0]    r_dv_den;
    logic [24:0]        r_r1;
    logic [24:0]        r_r2;
    logic [49:0]        r_var;
    logic [CO_W-1:0]    r_sv;
    logic [49:0]        r_sd2;
    logic [CO_W-1:0]    r_sa;
    logic [CO_W-1:0]    r_sb;
    logic [CO_W-1:0]    r_sap;
    logic [CO_W-1:0]    r_dir;
    logic [CO_W-1:0]    r_sd;

    logic [A_W-1:0]     a_eff;
    logic [P_W-1:0]     p_eff;
    logic [CO_W-1:0]    om_a;
    logic [CO_W-1:0]    om_p;
    logic [CO_W-1:0]    p_m_a;
    logic [47:0]        base;
    logic               dir_pos;
    logic [63:0]        sq_in;
    logic [34:0]        sq_t;
    logic [34:0]        sq_trial;
    logic               sq_ge;
    logic [34:0]        n_sq_rem;
    logic [31:0]        n_sq_root;
    logic [25:0]        dv_t;
    logic               dv_ge;
    logic [25:0]        n_dv_rem;
    logic [24:0]        n_dv_q;
    logic [41:0]        eta_prod;

    // Clamp the alphas into their legal ranges
    always_comb begin
        a_eff    = (i_alpha_now == '0) ? A_W'(1) : i_alpha_now;
        p_eff    = (i_alpha_before == '0) ? P_W'(1) :
                   ((i_alpha_before > CF_ONE) ? CF_ONE : i_alpha_before);
        om_a     = CF_ONE - {1'b0, a_eff};
        om_p     = CF_ONE - p_eff;
        p_m_a    = p_eff - {1'b0, a_eff};
        base     = {om_p[23:0], 24'd0};
        dir_pos  = {2'b00, base} > r_sd2;
        eta_prod = i_eta_level * r_sv;
    end

    // Select the radicand for the current state
    always_comb begin
        case (r_state)
            S_SA:    sq_in = {16'd0, a_eff, 24'd0};
            S_SB:    sq_in = {16'd0, om_a[23:0], 24'd0};
            S_SAP:   sq_in = {15'd0, p_eff, 24'd0};
            S_SV:    sq_in = {14'd0, r_var};
            default: sq_in = {16'd0, base - r_sd2[47:0]};
        endcase
    end

    // One root bit per cycle
    always_comb begin
        sq_t      = {r_sq_rem[32:0], r_sq_val[63:62]};
        sq_trial  = {1'b0, r_sq_root, 2'b01};
        sq_ge     = sq_t >= sq_trial;
        n_sq_rem  = sq_ge ? (sq_t - sq_trial) : sq_t;
        n_sq_root = {r_sq_root[30:0], sq_ge};
    end

    // One quotient bit per cycle
    always_comb begin
        dv_t     = {r_dv_rem[24:0], r_dv_num[47]};
        dv_ge    = dv_t >= {1'b0, r_dv_den};
        n_dv_rem = dv_ge ? (dv_t - {1'b0, r_dv_den}) : dv_t;
        n_dv_q   = {r_dv_q[23:0], dv_ge};
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SA;
            r_run   <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= S_SA;
            r_run   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_SA, S_SB, S_SAP, S_SV, S_DIR: begin
                    if (!r_run) begin
                        if (r_state == S_DIR && !dir_pos) begin
                            r_dir   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_sq_val  <= sq_in;
                            r_sq_rem  <= '0;
                            r_sq_root <= '0;
                            r_cnt     <= '0;
                            r_run     <= 1'b1;
                        end
                    end else begin
                        r_sq_val  <= {r_sq_val[61:0], 2'b00};
                        r_sq_rem  <= n_sq_rem;
                        r_sq_root <= n_sq_root;
                        r_cnt     <= r_cnt + 6'd1;
                        if (r_cnt == 6'd31) begin
                            r_run <= 1'b0;
                            case (r_state)
                                S_SA: begin
                                    r_sa    <= n_sq_root[CO_W-1:0];
                                    r_state <= S_SB;
                                end
                                S_SB: begin
                                    r_sb    <= n_sq_root[CO_W-1:0];
                                    r_state <= S_SAP;
                                end
                                S_SAP: begin
                                    r_sap   <= n_sq_root[CO_W-1:0];
                                    r_state <= S_R1;
                                end
                                S_SV: begin
                                    r_sv    <= n_sq_root[CO_W-1:0];
                                    r_state <= S_SD;
                                end
                                default: begin
                                    r_dir   <= n_sq_root[CO_W-1:0];
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_R1, S_R2: begin
                    if (!r_run) begin
                        if (r_state == S_R1 && !(p_eff > {1'b0, a_eff})) begin
                            r_var   <= '0;
                            r_state <= S_SV;
                        end else begin
                            r_dv_num <= (r_state == S_R1) ? {om_p[23:0], 24'd0}
                                                          : {p_m_a[23:0], 24'd0};
                            r_dv_den <= (r_state == S_R1) ? om_a : p_eff;
                            r_dv_rem <= '0;
                            r_dv_q   <= '0;
                            r_cnt    <= '0;
                            r_run    <= 1'b1;
                        end
                    end else begin
                        r_dv_num <= {r_dv_num[46:0], 1'b0};
                        r_dv_rem <= n_dv_rem;
                        r_dv_q   <= n_dv_q;
                        r_cnt    <= r_cnt + 6'd1;
                        if (r_cnt == 6'd47) begin
                            r_run <= 1'b0;
                            if (r_state == S_R1) begin
                                r_r1    <= n_dv_q;
                                r_state <= S_R2;
                            end else begin
                                r_r2    <= n_dv_q;
                                r_state <= S_VAR;
                            end
                        end
                    end
                end
                S_VAR: begin
                    r_var   <= r_r1 * r_r2;
                    r_state <= S_SV;
                end
                S_SD: begin
                    r_sd    <= eta_prod[40:16];
                    r_state <= S_SD2;
                end
                S_SD2: begin
                    r_sd2   <= r_sd * r_sd;
                    r_state <= S_DIR;
                end
                S_DONE: begin
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_SA;
                end
            endcase
        end
    end

    assign o_coef = '{sa: r_sa, sb: r_sb, sap: r_sap, dir: r_dir, sd: r_sd};
    assign o_busy = (r_state != S_DONE);

    // Hold the finished set until the next restart
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_start) |=> (r_state == S_DONE))
        else $error("coefficient set left done state without restart");

    // Root coefficients never fall below the smallest root
    a_div_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_sa >= SQ_MIN && r_sb >= SQ_MIN && r_sap >= SQ_MIN))
        else $error("root coefficient below minimum");

    // Direction scale stays within 1.0
    a_dir_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_dir <= CF_ONE))
        else $error("direction scale above one");

endmodule

>>> src/ddim_pipe.sv
// Element datapath: products, pipelined restoring divider, final blend and saturation.
`timescale 1ns / 1ps
module ddim_pipe #(
    parameter int DATA_WIDTH = ddim_pkg::DEF_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_hold,
    input  ddim_pkg::t_coef                     i_coef,
    input  logic [ddim_pkg::MODE_W-1:0]         i_mode,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]        i_x,
    input  logic signed [DATA_WIDTH-1:0]        i_m,
    input  logic signed [DATA_WIDTH-1:0]        i_n,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [DATA_WIDTH-1:0]        o_y
);
    import ddim_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int PW    = W + 26;
    localparam int SW    = W + 27;
    localparam int NW    = W + 25;
    localparam int QB    = W + 13;
    localparam int NS    = QB + 8;
    localparam int ST_F  = QB + 3;
    localparam int ST_P  = QB + 4;
    localparam int ST_S1 = QB + 5;
    localparam int ST_S2 = QB + 6;
    localparam int ST_O  = QB + 7;
    localparam int AW    = 64;
    localparam int LO_W  = 19;
    localparam int HI_W  = MID_W - LO_W;

    localparam logic signed [SW-1:0] RND_S = SW'(1) <<< (CF_BITS - 1);
    localparam logic signed [SW-1:0] LIM_S = SW'(MID_LIM);
    localparam logic signed [AW-1:0] RND_A = AW'(1) <<< (CF_BITS - 1);
    localparam logic signed [AW-1:0] Y_MAX = (AW'(1) <<< (W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);

    typedef struct packed {
        logic                      neg;
        logic signed [W-1:0]       m;
        logic signed [W-1:0]       n;
        logic signed [MID_W-1:0]   x0v;
        logic signed [MID_W-1:0]   epsv;
    } t_side;

    function automatic logic signed [MID_W-1:0] clamp_mid(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        begin
            c = v;
            if (v > LIM_S)
                c = LIM_S;
            else if (v < -LIM_S)
                c = -LIM_S;
            return MID_W'(c);
        end
    endfunction

    logic [NS-1:0]  r_v;
    logic [NS-1:0]  en;
    logic [NS-1:0]  n_v;
    logic           accept;

    // Stall chain: a stage moves when empty or when the one after it moves
    assign en[NS-1] = !r_v[NS-1] || !i_out_stall;
    genvar gk;
    generate
        for (gk = 0; gk < NS - 1; gk++) begin : g_en
            assign en[gk] = !r_v[gk] || en[gk + 1];
        end
    endgenerate

    assign o_in_stall = i_hold || !en[0];
    assign accept     = i_in_valid && !o_in_stall;
    assign n_v        = {r_v[NS-2:0], accept};

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (n_v & en) | (r_v & ~en);
        end
    end

    // Stage 0: capture the transfer
    logic signed [W-1:0] r0_x, r0_m, r0_n;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_x <= i_x;
            r0_m <= i_m;
            r0_n <= i_n;
        end
    end

    // Stage 1: root products
    logic signed [25:0]   sa_s, sb_s;
    logic signed [PW-1:0] r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [W-1:0]  r1_x, r1_m, r1_n;
    assign sa_s = $signed({1'b0, i_coef.sa});
    assign sb_s = $signed({1'b0, i_coef.sb});
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_pa <= sa_s * r0_x;
            r1_pb <= sb_s * r0_m;
            r1_pc <= sa_s * r0_m;
            r1_pd <= sb_s * r0_x;
            r1_x  <= r0_x;
            r1_m  <= r0_m;
            r1_n  <= r0_n;
        end
    end

    // Stage 2: numerator for the divider, rounded v-prediction terms
    logic signed [SW-1:0] xs, num, num_abs, v_a, v_b, v_ar, v_br;
    logic [CO_W-1:0]      den;
    logic [NW-1:0]        r2_mag;
    t_side                r2_side;
    always_comb begin
        xs      = SW'(r1_x) <<< CF_BITS;
        num     = (i_mode == MODE_SAMPLE) ? (xs - SW'(r1_pc)) : (xs - SW'(r1_pb));
        num_abs = (num < 0) ? -num : num;
        v_a     = SW'(r1_pa) - SW'(r1_pb);
        v_b     = SW'(r1_pc) + SW'(r1_pd);
        v_ar    = (v_a + RND_S) >>> CF_BITS;
        v_br    = (v_b + RND_S) >>> CF_BITS;
        den     = (i_mode == MODE_SAMPLE) ? i_coef.sb : i_coef.sa;
    end
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_mag       <= num_abs[NW-1:0];
            r2_side.neg  <= (num < 0);
            r2_side.m    <= r1_m;
            r2_side.n    <= r1_n;
            r2_side.x0v  <= clamp_mid(v_ar);
            r2_side.epsv <= clamp_mid(v_br);
        end
    end

    // Divider: one quotient bit per stage, most significant first
    logic [NW-1:0] w_rem  [0:QB];
    logic [QB-1:0] w_q    [0:QB];
    t_side         w_side [0:QB];
    assign w_rem[0]  = r2_mag;
    assign w_q[0]    = '0;
    assign w_side[0] = r2_side;

    genvar gj;
    generate
        for (gj = 0; gj < QB; gj++) begin : g_div
            localparam int BI = QB - 1 - gj;
            logic [NW-1:0] sh;
            logic          ge;
            logic [NW-1:0] r_rem;
            logic [QB-1:0] r_q;
            t_side         r_side;
            assign sh = w_rem[gj] >> BI;
            assign ge = sh >= NW'(den);
            always_ff @(posedge i_clk) begin
                if (en[3 + gj]) begin
                    r_rem  <= ge ? (w_rem[gj] - (NW'(den) << BI)) : w_rem[gj];
                    r_q    <= ge ? (w_q[gj] | (QB'(1) << BI)) : w_q[gj];
                    r_side <= w_side[gj];
                end
            end
            assign w_rem[gj + 1]  = r_rem;
            assign w_q[gj + 1]    = r_q;
            assign w_side[gj + 1] = r_side;
        end
    endgenerate

    // Stage F: pick x0 and eps for the mode
    logic [MID_W-1:0]        dmag;
    logic signed [MID_W-1:0] dres, m_ext;
    logic signed [MID_W-1:0] r_x0, r_eps;
    logic signed [W-1:0]     rf_n;
    always_comb begin
        dmag  = (64'(w_q[QB]) > 64'(MID_LIM)) ? MID_LIM : MID_W'(w_q[QB]);
        dres  = w_side[QB].neg ? -$signed(dmag) : $signed(dmag);
        m_ext = MID_W'(w_side[QB].m);
    end
    always_ff @(posedge i_clk) begin
        if (en[ST_F]) begin
            case (i_mode)
                MODE_SAMPLE: begin
                    r_x0  <= m_ext;
                    r_eps <= dres;
                end
                MODE_VPRED: begin
                    r_x0  <= w_side[QB].x0v;
                    r_eps <= w_side[QB].epsv;
                end
                default: begin
                    r_x0  <= dres;
                    r_eps <= m_ext;
                end
            endcase
            rf_n <= w_side[QB].n;
        end
    end

    // Stage P: split products of the blend
    logic signed [25:0]       sap_s, dir_s, sd_s;
    logic signed [LO_W+25:0]  r_pxl, r_pel;
    logic signed [HI_W+25:0]  r_pxh, r_peh;
    logic signed [W+25:0]     r_psn;
    assign sap_s = $signed({1'b0, i_coef.sap});
    assign dir_s = $signed({1'b0, i_coef.dir});
    assign sd_s  = $signed({1'b0, i_coef.sd});
    always_ff @(posedge i_clk) begin
        if (en[ST_P]) begin
            r_pxl <= sap_s * $signed({1'b0, r_x0[LO_W-1:0]});
            r_pxh <= sap_s * $signed(r_x0[MID_W-1:LO_W]);
            r_pel <= dir_s * $signed({1'b0, r_eps[LO_W-1:0]});
            r_peh <= dir_s * $signed(r_eps[MID_W-1:LO_W]);
            r_psn <= sd_s * rf_n;
        end
    end

    // Stage S1: recombine halves
    logic signed [AW-1:0] r_t1, r_t2, r_t3;
    always_ff @(posedge i_clk) begin
        if (en[ST_S1]) begin
            r_t1 <= (AW'(r_pxh) <<< LO_W) + AW'(r_pxl);
            r_t2 <= (AW'(r_peh) <<< LO_W) + AW'(r_pel);
            r_t3 <= AW'(r_psn);
        end
    end

    // Stage S2: accumulate
    logic signed [AW-1:0] r_acc;
    always_ff @(posedge i_clk) begin
        if (en[ST_S2]) begin
            r_acc <= r_t1 + r_t2 + r_t3;
        end
    end

    // Output stage: round half up and saturate
    logic signed [AW-1:0] rnd;
    logic signed [W-1:0]  r_y;
    assign rnd = (r_acc + RND_A) >>> CF_BITS;
    always_ff @(posedge i_clk) begin
        if (en[ST_O]) begin
            if (rnd > Y_MAX)
                r_y <= W'(Y_MAX);
            else if (rnd < Y_MIN)
                r_y <= W'(Y_MIN);
            else
                r_y <= W'(rnd);
        end
    end

    assign o_out_valid = r_v[NS-1];
    assign o_y         = r_y;

endmodule

>>> src/ddim_diffusion_step_unit.sv
// DDIM step unit top level: configuration registers, coefficient engine, element pipeline.
`timescale 1ns / 1ps
// Usage:
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   alpha_now (0), alpha_before (1), eta_level (2) and prediction_mode (3). Write only
//   while no element is in flight. Each write, and reset, starts the coefficient engine,
//   which runs up to five 32-step square roots, two 48-step divisions and three
//   products; o_in_stall stays high meanwhile.
//   Input channel (i_in_valid / o_in_stall) carries current_sample, model_prediction and
//   noise_sample; output channel (o_out_valid / i_out_stall) carries previous_sample.
//   Throughput is one element per cycle while neither the coefficient engine nor the
//   receiver stalls; the divider inside the pipeline resolves one quotient bit per stage.
//   When the receiver stalls, the result holds in the output register and bubbles in the
//   pipeline close up, so inputs are still taken until every stage is full.
//   Reset returns the registers to alpha_now 0.5, alpha_before 1.0, eta 0, epsilon mode
//   and empties the pipeline.
module ddim_diffusion_step_unit #(
    parameter int DATA_WIDTH = ddim_pkg::DEF_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ddim_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ddim_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]        i_current_sample,
    input  logic signed [DATA_WIDTH-1:0]        i_model_prediction,
    input  logic signed [DATA_WIDTH-1:0]        i_noise_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [DATA_WIDTH-1:0]        o_previous_sample
);
    import ddim_pkg::*;

    logic [A_W-1:0]     r_alpha_now;
    logic [P_W-1:0]     r_alpha_before;
    logic [E_W-1:0]     r_eta_level;
    logic [MODE_W-1:0]  r_pred_mode;
    logic               cfg_we;
    logic               w_busy;
    t_coef              w_coef;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_now    <= ALPHA_NOW_RST;
            r_alpha_before <= ALPHA_BEFORE_RST;
            r_eta_level    <= ETA_LEVEL_RST;
            r_pred_mode    <= MODE_EPS;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA_NOW:    r_alpha_now    <= i_cfg_data[A_W-1:0];
                CFG_ALPHA_BEFORE: r_alpha_before <= i_cfg_data[P_W-1:0];
                CFG_ETA_LEVEL:    r_eta_level    <= i_cfg_data[E_W-1:0];
                CFG_PRED_MODE:    r_pred_mode    <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Recompute the per-step coefficients
    ddim_coef u_coef (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (cfg_we),
        .i_alpha_now    (r_alpha_now),
        .i_alpha_before (r_alpha_before),
        .i_eta_level    (r_eta_level),
        .o_coef         (w_coef),
        .o_busy         (w_busy)
    );

    // Element pipeline
    ddim_pipe #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_busy),
        .i_coef      (w_coef),
        .i_mode      (r_pred_mode),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x         (i_current_sample),
        .i_m         (i_model_prediction),
        .i_n         (i_noise_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_y         (o_previous_sample)
    );

    // No transfer while coefficients are being rebuilt
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_in_stall)
        else $error("input taken while coefficients busy");

    // A register write restarts the coefficient engine
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> w_busy)
        else $error("register write did not restart coefficients");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

>>> tb/ddim_diffusion_step_unit_test.sv
// Self-checking testbench for the DDIM step unit: directed table, random phases, predictor.
`timescale 1ns / 1ps
module ddim_diffusion_step_unit_test;
    import ddim_pkg::*;

    localparam int DW        = DEF_DATA_WIDTH;
    localparam int SETTLE    = 60;
    localparam int WDOG_LIM  = 4000;
    localparam int PER_PHASE = 80;
    localparam longint unsigned CF1 = 64'd1 << CF_BITS;
    localparam longint MID_MAX = (64'sd1 <<< 36) - 1;

    typedef logic signed [DW-1:0] t_elem;

    typedef struct {
        t_elem x;
        t_elem m;
        t_elem n;
        bit    fixed;
        t_elem want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_elem                 i_current_sample;
    t_elem                 i_model_prediction;
    t_elem                 i_noise_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_elem                 o_previous_sample;

    // Shadow registers of the block
    logic [A_W-1:0]    sh_alpha_now;
    logic [P_W-1:0]    sh_alpha_before;
    logic [E_W-1:0]    sh_eta;
    logic [MODE_W-1:0] sh_mode;

    t_elem pending_samples[$];
    int    errors;
    int    idle_cycles;
    bit    row_fixed;
    t_elem row_want;
    bit    tx_quiet;
    bit    rx_quiet;
    int    rx_wait;

    ddim_diffusion_step_unit #(.DATA_WIDTH(DW)) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_current_sample   (i_current_sample),
        .i_model_prediction (i_model_prediction),
        .i_noise_sample     (i_noise_sample),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_previous_sample  (o_previous_sample)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clamp_mid(longint v);
        if (v > MID_MAX) return MID_MAX;
        if (v < -MID_MAX) return -MID_MAX;
        return v;
    endfunction

    // Round half up from Q.24 products; arithmetic shift floors
    function automatic longint round_q24(longint v);
        return (v + (64'sd1 <<< (CF_BITS - 1))) >>> CF_BITS;
    endfunction

    // Previous sample from the current shadow registers
    function automatic t_elem predict_prev_sample(t_elem xi, t_elem mi, t_elem ni);
        longint unsigned a, p, sa, sb, sap, var48, sd, sd2, base, dscale, r1, r2;
        longint x, m, n, x0, eps, acc, r, hi, lo;
        a = (sh_alpha_now == 0) ? 1 : sh_alpha_now;
        p = (sh_alpha_before == 0) ? 1 : sh_alpha_before;
        if (a >= CF1) a = CF1 - 1;
        if (p > CF1) p = CF1;
        sa  = int_sqrt(a << CF_BITS);
        sb  = int_sqrt((CF1 - a) << CF_BITS);
        sap = int_sqrt(p << CF_BITS);
        var48 = 0;
        if (p > a) begin
            r1 = ((CF1 - p) << CF_BITS) / (CF1 - a);
            r2 = ((p - a) << CF_BITS) / p;
            var48 = r1 * r2;
        end
        sd  = (longint'(sh_eta) * int_sqrt(var48)) >> 16;
        sd2 = sd * sd;
        base = (CF1 - p) << CF_BITS;
        dscale = (base > sd2) ? int_sqrt(base - sd2) : 0;
        x = xi;
        m = mi;
        n = ni;
        case (sh_mode)
            MODE_SAMPLE: begin
                x0  = m;
                eps = clamp_mid((x * longint'(CF1) - longint'(sa) * m) / longint'(sb));
            end
            MODE_VPRED: begin
                x0  = clamp_mid(round_q24(longint'(sa) * x - longint'(sb) * m));
                eps = clamp_mid(round_q24(longint'(sa) * m + longint'(sb) * x));
            end
            default: begin
                x0  = clamp_mid((x * longint'(CF1) - longint'(sb) * m) / longint'(sa));
                eps = m;
            end
        endcase
        acc = longint'(sap) * x0 + longint'(dscale) * eps;
        if (sd > 0) acc += longint'(sd) * n;
        r  = round_q24(acc);
        hi = (64'sd1 <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return t_elem'(r);
    endfunction

    task automatic report(string what, t_elem got, t_elem want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // Queue expectations on input transfers, check output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pending_samples.push_back(row_fixed ? row_want :
                    predict_prev_sample(i_current_sample, i_model_prediction,
                                        i_noise_sample));
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    report("unexpected previous_sample", o_previous_sample, '0);
                end else begin
                    if (o_previous_sample !== pending_samples[0])
                        report("previous_sample", o_previous_sample, pending_samples[0]);
                    void'(pending_samples.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIM) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall per result, with quiet stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) rx_quiet = ~rx_quiet;
        if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid && !rx_quiet) rx_wait = $urandom_range(0, 14);
        end
    end

    // Hold one register write until taken
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ALPHA_NOW:    sh_alpha_now    = val[A_W-1:0];
            CFG_ALPHA_BEFORE: sh_alpha_before = val[P_W-1:0];
            CFG_ETA_LEVEL:    sh_eta          = val[E_W-1:0];
            CFG_PRED_MODE:    sh_mode         = val[MODE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drain the pipeline, then rewrite every register
    task automatic set_step(logic [CFG_DATA_W-1:0] a, logic [CFG_DATA_W-1:0] p,
                            logic [CFG_DATA_W-1:0] eta, logic [CFG_DATA_W-1:0] mode);
        i_in_valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        write_reg(CFG_ALPHA_NOW, a);
        write_reg(CFG_ALPHA_BEFORE, p);
        write_reg(CFG_ETA_LEVEL, eta);
        write_reg(CFG_PRED_MODE, mode);
        // unmapped index: must leave the step untouched
        if ($urandom_range(0, 2) == 0) write_reg(4'hF, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        tx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Offer one element, starting and ending on a falling edge
    task automatic send_element(t_row row);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_fixed = row.fixed;
        row_want  = row.want;
        i_current_sample   <= row.x;
        i_model_prediction <= row.m;
        i_noise_sample     <= row.n;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    function automatic t_elem rand_elem(bit narrow);
        if (!narrow || $urandom_range(0, 3) == 0) return t_elem'($urandom);
        return t_elem'($urandom_range(0, 1 << 19)) - t_elem'(1 << 18);
    endfunction

    localparam t_elem EMAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_elem EMIN = {1'b1, {(DW-1){1'b0}}};

    // Directed rows at reset settings: epsilon mode, no deviation
    t_row dir_rows[] = '{
        '{t_elem'(0), t_elem'(0), t_elem'(0),  1'b1, t_elem'(0)},
        '{t_elem'(0), t_elem'(0), EMAX,        1'b1, t_elem'(0)},
        '{t_elem'(0), t_elem'(0), EMIN,        1'b1, t_elem'(0)},
        '{EMAX,       t_elem'(0), t_elem'(0),  1'b0, t_elem'(0)},
        '{EMIN,       t_elem'(0), t_elem'(0),  1'b0, t_elem'(0)},
        '{t_elem'(0), EMAX,       t_elem'(0),  1'b0, t_elem'(0)},
        '{t_elem'(0), EMIN,       t_elem'(0),  1'b0, t_elem'(0)},
        '{EMAX,       EMAX,       EMAX,        1'b0, t_elem'(0)},
        '{EMIN,       EMIN,       EMIN,        1'b0, t_elem'(0)},
        '{EMAX,       EMIN,       EMAX,        1'b0, t_elem'(0)},
        '{EMIN,       EMAX,       EMIN,        1'b0, t_elem'(0)},
        '{t_elem'(-1), t_elem'(1), t_elem'(-1), 1'b0, t_elem'(0)},
        '{t_elem'(65536), t_elem'(-65536), t_elem'(65536), 1'b0, t_elem'(0)}
    };

    // Step settings: extremes first, then random
    logic [CFG_DATA_W-1:0] step_set[6][4] = '{
        '{25'd0,        25'd0,        25'd131071, 25'(MODE_EPS)},
        '{25'd1,        25'h1FF_FFFF, 25'd131071, 25'(MODE_SAMPLE)},
        '{25'hFF_FFFF,  25'h100_0000, 25'd65536,  25'(MODE_VPRED)},
        '{25'hFF_FFFF,  25'd1,        25'd0,      25'd3},
        '{25'h80_0000,  25'h80_0000,  25'd65536,  25'(MODE_EPS)},
        '{25'h01_0000,  25'hFF_0000,  25'd131071, 25'(MODE_VPRED)}
    };

    initial begin
        t_row row;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_current_sample = '0;
        i_model_prediction = '0;
        i_noise_sample = '0;
        i_out_stall = 1'b0;
        errors = 0;
        idle_cycles = 0;
        row_fixed = 1'b0;
        row_want = '0;
        rx_quiet = 1'b0;
        rx_wait = 0;
        tx_quiet = 1'b0;
        sh_alpha_now = ALPHA_NOW_RST;
        sh_alpha_before = ALPHA_BEFORE_RST;
        sh_eta = ETA_LEVEL_RST;
        sh_mode = MODE_EPS;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at reset values
        foreach (dir_rows[k]) send_element(dir_rows[k]);

        // Random phases over fixed and random settings
        for (int ph = 0; ph < 11; ph++) begin
            if (ph < 6)
                set_step(step_set[ph][0], step_set[ph][1], step_set[ph][2], step_set[ph][3]);
            else
                set_step(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 1 << 24)),
                         CFG_DATA_W'($urandom_range(0, 131071)),
                         CFG_DATA_W'($urandom_range(0, 3)));
            for (int k = 0; k < PER_PHASE; k++) begin
                row.x = rand_elem(1'b1);
                row.m = rand_elem(1'b1);
                row.n = rand_elem(1'b1);
                row.fixed = 1'b0;
                row.want = '0;
                send_element(row);
            end
        end

        i_in_valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
